// ===== design/butterworth_pole_generator_top_macros.svh =====
// Assertion helpers for the pole generator.
`ifndef BUTTERWORTH_POLE_GENERATOR_TOP_MACROS_SVH
`define BUTTERWORTH_POLE_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define BPG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpg: implication check failed");

// next-cycle implication
`define BPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpg: next-cycle check failed");

`endif

// ===== design/bpg_pkg.sv =====
`timescale 1ns / 1ps

package bpg_pkg;

  localparam int PC_W = 4;
  localparam int CW   = 34;

  typedef logic [PC_W-1:0] pc_t;
  typedef logic signed [CW-1:0] cval_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_EMIT_REAL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_COR_INIT,
    OP_COR_STEP,
    OP_EMIT_PAIR
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_OUT_BUSY,
    COND_EVEN,
    COND_PAIRS_DONE,
    COND_DIV_MORE,
    COND_COR_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic out_busy;
    logic even;
    logic pairs_done;
    logic div_more;
    logic cor_more;
  } flags_t;

  localparam pc_t STEP_IDLE      = 4'd0;
  localparam pc_t STEP_ODD_TEST  = 4'd1;
  localparam pc_t STEP_EMIT_REAL = 4'd2;
  localparam pc_t STEP_PAIR_TEST = 4'd3;
  localparam pc_t STEP_DIV_INIT  = 4'd4;
  localparam pc_t STEP_DIV       = 4'd5;
  localparam pc_t STEP_COR_INIT  = 4'd6;
  localparam pc_t STEP_COR       = 4'd7;
  localparam pc_t STEP_EMIT_PAIR = 4'd8;
  localparam pc_t STEP_LOOP      = 4'd9;

  localparam logic [31:0] PI_Q30     = 32'hC90FDAA2;
  localparam cval_t       INV_GAIN   = 34'sh26DD3B6A;
  localparam logic [4:0]  COR_LAST   = 5'd30;
  localparam logic signed [15:0] SAT_HI = 16'sh7FFF;
  localparam logic signed [15:0] SAT_LO = -16'sh8000;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      STEP_IDLE:      w = '{OP_LOAD,      COND_NO_INPUT,   STEP_IDLE};
      STEP_ODD_TEST:  w = '{OP_NONE,      COND_EVEN,       STEP_PAIR_TEST};
      STEP_EMIT_REAL: w = '{OP_EMIT_REAL, COND_OUT_BUSY,   STEP_EMIT_REAL};
      STEP_PAIR_TEST: w = '{OP_NONE,      COND_PAIRS_DONE, STEP_IDLE};
      STEP_DIV_INIT:  w = '{OP_DIV_INIT,  COND_NEVER,      STEP_IDLE};
      STEP_DIV:       w = '{OP_DIV_STEP,  COND_DIV_MORE,   STEP_DIV};
      STEP_COR_INIT:  w = '{OP_COR_INIT,  COND_NEVER,      STEP_IDLE};
      STEP_COR:       w = '{OP_COR_STEP,  COND_COR_MORE,   STEP_COR};
      STEP_EMIT_PAIR: w = '{OP_EMIT_PAIR, COND_OUT_BUSY,   STEP_EMIT_PAIR};
      STEP_LOOP:      w = '{OP_NONE,      COND_ALWAYS,     STEP_PAIR_TEST};
      default:        w = '{OP_NONE,      COND_ALWAYS,     STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic cval_t atan_q30(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h3243F6A8;
      5'd1:  a = 32'h1DAC6705;
      5'd2:  a = 32'h0FADBAFC;
      5'd3:  a = 32'h07F56EA6;
      5'd4:  a = 32'h03FEAB76;
      5'd5:  a = 32'h01FFD55B;
      5'd6:  a = 32'h00FFFAAA;
      5'd7:  a = 32'h007FFF55;
      5'd8:  a = 32'h003FFFEA;
      5'd9:  a = 32'h001FFFFD;
      5'd10: a = 32'h000FFFFF;
      5'd11: a = 32'h0007FFFF;
      5'd12: a = 32'h0003FFFF;
      5'd13: a = 32'h0001FFFF;
      5'd14: a = 32'h0000FFFF;
      5'd15: a = 32'h00007FFF;
      5'd16: a = 32'h00003FFF;
      5'd17: a = 32'h00001FFF;
      5'd18: a = 32'h00000FFF;
      5'd19: a = 32'h000007FF;
      5'd20: a = 32'h000003FF;
      5'd21: a = 32'h000001FF;
      5'd22: a = 32'h000000FF;
      5'd23: a = 32'h0000007F;
      5'd24: a = 32'h0000003F;
      5'd25: a = 32'h0000001F;
      5'd26: a = 32'h0000000F;
      5'd27: a = 32'h00000008;
      5'd28: a = 32'h00000004;
      5'd29: a = 32'h00000002;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return $signed({2'b00, a});
  endfunction

  function automatic logic [15:0] sat16(input cval_t v);
    logic [15:0] r;
    if (v > cval_t'(SAT_HI)) begin
      r = SAT_HI;
    end else if (v < cval_t'(SAT_LO)) begin
      r = SAT_LO;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== design/butterworth_pole_generator_top.sv =====
// After an order is accepted, the real pole (odd order) is emitted first, then each pole pair in turn.
// A stalled output holds the microcode at its emit step until the pending pole has been taken.
// Each pole pair is computed by the 37-step shift-subtract divider and the 31-step CORDIC loop.
// A new order is taken only at the idle microcode step; a result may still wait in the output.
// Reset (rst, synchronous) returns the step counter to idle and empties the output register.
`timescale 1ns / 1ps

`include "butterworth_pole_generator_top_macros.svh"

module butterworth_pole_generator_top #(
  parameter int MAX_ORDER = 16,
  parameter int FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               order_valid,
  output logic               order_stall,
  input  logic [4:0]         order,
  output logic               pole_valid,
  input  logic               pole_stall,
  output logic signed [15:0] pole_real,
  output logic signed [15:0] pole_imag,
  output logic               section_kind,
  output logic [3:0]         section_number,
  output logic               last_section
);

  bpg_pkg::op_t    op;
  bpg_pkg::flags_t flags;

  assign order_stall = op != bpg_pkg::OP_LOAD;

  bpg_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .order_valid (order_valid),
    .flags       (flags),
    .op          (op)
  );

  bpg_dp #(
    .MAX_ORDER (MAX_ORDER),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .order_valid    (order_valid),
    .order          (order),
    .pole_stall     (pole_stall),
    .flags          (flags),
    .pole_valid     (pole_valid),
    .pole_real      (pole_real),
    .pole_imag      (pole_imag),
    .section_kind   (section_kind),
    .section_number (section_number),
    .last_section   (last_section)
  );

  `BPG_ASSERT_NEXT(a_leave_idle, order_valid && !order_stall, order_stall)
  `BPG_ASSERT_IMPL(a_real_no_imag, pole_valid && !section_kind, pole_imag == 16'sd0)
  `BPG_ASSERT_IMPL(a_pair_left_half, pole_valid && section_kind, pole_real <= 16'sd0)

endmodule

// ===== design/bpg_seq.sv =====
`timescale 1ns / 1ps

module bpg_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            order_valid,
  input  bpg_pkg::flags_t flags,
  output bpg_pkg::op_t    op
);

  bpg_pkg::pc_t    pc;
  bpg_pkg::pc_t    pc_next;
  bpg_pkg::uword_t uw;
  logic            jump;

  always_comb begin
    uw = bpg_pkg::ucode(pc);
    case (uw.cond)
      bpg_pkg::COND_NEVER:      jump = 1'b0;
      bpg_pkg::COND_ALWAYS:     jump = 1'b1;
      bpg_pkg::COND_NO_INPUT:   jump = !order_valid;
      bpg_pkg::COND_OUT_BUSY:   jump = flags.out_busy;
      bpg_pkg::COND_EVEN:       jump = flags.even;
      bpg_pkg::COND_PAIRS_DONE: jump = flags.pairs_done;
      bpg_pkg::COND_DIV_MORE:   jump = flags.div_more;
      bpg_pkg::COND_COR_MORE:   jump = flags.cor_more;
      default:                  jump = 1'b0;
    endcase
    pc_next = jump ? uw.target : pc + bpg_pkg::pc_t'(1);
    op      = uw.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= bpg_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== design/bpg_dp.sv =====
`timescale 1ns / 1ps

module bpg_dp #(
  parameter int MAX_ORDER = 16,
  parameter int FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  bpg_pkg::op_t       op,
  input  logic               order_valid,
  input  logic [4:0]         order,
  input  logic               pole_stall,
  output bpg_pkg::flags_t    flags,
  output logic               pole_valid,
  output logic signed [15:0] pole_real,
  output logic signed [15:0] pole_imag,
  output logic               section_kind,
  output logic [3:0]         section_number,
  output logic               last_section
);

  localparam int NMAX   = (MAX_ORDER < 31) ? MAX_ORDER : 31;
  localparam int DIV_W  = $clog2(2 * NMAX + 1);
  localparam int NUM_W  = 32 + $clog2(NMAX + 2);
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int RND_SH = 30 - FRAC_BITS;
  localparam bpg_pkg::cval_t HALF_LSB = bpg_pkg::cval_t'((64'sd1 <<< RND_SH) >>> 1);
  localparam bpg_pkg::cval_t ONE_FRAC = bpg_pkg::cval_t'(64'sd1 <<< FRAC_BITS);

  logic [4:0]       n_load;
  logic [3:0]       half;
  logic             odd;
  logic [4:0]       k;
  logic [3:0]       sect;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] div;
  logic [CNT_W-1:0] dcnt;
  logic [DIV_W:0]   r_sh;
  logic             ge;
  logic [DIV_W:0]   r_sub;
  logic [4:0]       icnt;
  bpg_pkg::cval_t   x;
  bpg_pkg::cval_t   y;
  bpg_pkg::cval_t   z;
  bpg_pkg::cval_t   xs;
  bpg_pkg::cval_t   ys;
  bpg_pkg::cval_t   ang;
  bpg_pkg::cval_t   rx;
  bpg_pkg::cval_t   ry;
  logic             load_fire;
  logic             emit_ok;

  always_comb begin
    n_load = ({2'b00, order} > 7'(MAX_ORDER)) ? 5'(MAX_ORDER) : order;
    r_sh   = {rem, quo[NUM_W-1]};
    ge     = r_sh >= {1'b0, div};
    r_sub  = r_sh - {1'b0, div};
    xs     = x >>> icnt;
    ys     = y >>> icnt;
    ang    = bpg_pkg::atan_q30(icnt);
    rx     = (x + HALF_LSB) >>> RND_SH;
    ry     = (y + HALF_LSB) >>> RND_SH;
    load_fire = (op == bpg_pkg::OP_LOAD) && order_valid;
    flags.out_busy   = pole_valid && pole_stall;
    flags.even       = !odd;
    flags.pairs_done = k > {1'b0, half};
    flags.div_more   = dcnt != '0;
    flags.cor_more   = icnt != bpg_pkg::COR_LAST;
    emit_ok = !flags.out_busy;
  end

  always_ff @(posedge clk) begin
    case (op)
      bpg_pkg::OP_LOAD: begin
        if (load_fire) begin
          half <= n_load[4:1];
          odd  <= n_load[0];
          div  <= DIV_W'({n_load, 1'b0});
          k    <= 5'd1;
          sect <= '0;
          num  <= NUM_W'(bpg_pkg::PI_Q30);
        end
      end
      bpg_pkg::OP_DIV_INIT: begin
        quo  <= num;
        rem  <= '0;
        dcnt <= CNT_W'(NUM_W - 1);
      end
      bpg_pkg::OP_DIV_STEP: begin
        rem  <= ge ? r_sub[DIV_W-1:0] : r_sh[DIV_W-1:0];
        quo  <= {quo[NUM_W-2:0], ge};
        dcnt <= dcnt - CNT_W'(1);
      end
      bpg_pkg::OP_COR_INIT: begin
        x    <= bpg_pkg::INV_GAIN;
        y    <= '0;
        z    <= $signed({2'b00, quo[31:0]});
        icnt <= '0;
      end
      bpg_pkg::OP_COR_STEP: begin
        if (!z[bpg_pkg::CW-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - ang;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + ang;
        end
        icnt <= icnt + 5'd1;
      end
      bpg_pkg::OP_EMIT_REAL: begin
        if (emit_ok) begin
          pole_real      <= bpg_pkg::sat16(-ONE_FRAC);
          pole_imag      <= '0;
          section_kind   <= 1'b0;
          section_number <= sect + 4'd1;
          last_section   <= half == 4'd0;
          sect           <= sect + 4'd1;
        end
      end
      bpg_pkg::OP_EMIT_PAIR: begin
        if (emit_ok) begin
          pole_real      <= bpg_pkg::sat16(-ry);
          pole_imag      <= bpg_pkg::sat16(rx);
          section_kind   <= 1'b1;
          section_number <= sect + 4'd1;
          last_section   <= k == {1'b0, half};
          sect           <= sect + 4'd1;
          k              <= k + 5'd1;
          num            <= num + NUM_W'({bpg_pkg::PI_Q30, 1'b0});
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pole_valid <= 1'b0;
    end else if (((op == bpg_pkg::OP_EMIT_REAL) || (op == bpg_pkg::OP_EMIT_PAIR)) && emit_ok) begin
      pole_valid <= 1'b1;
    end else if (!pole_stall) begin
      pole_valid <= 1'b0;
    end
  end

endmodule
